FILE: src/uer_pkg.sv
// Package for the echo pulse-width ranger: field widths, register indexes,
// reset values and the centimetre divisor.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package uer_pkg;

  // Field and register widths
  localparam int HOLDOFF_BITS   = 20;
  localparam int TRIGGER_BITS   = 10;
  localparam int DIST_BITS      = 11;
  localparam int CFG_DATA_BITS  = 20;
  localparam int CFG_INDEX_BITS = 1;

  // Default echo counter width (module parameter default)
  localparam int ECHO_COUNT_BITS_DEF = 16;

  // Echo ticks per centimetre and the remainder counter width
  localparam int TICKS_PER_CM = 59;
  localparam int REM_BITS     = 6;

  // Register reset values
  localparam logic [HOLDOFF_BITS-1:0] HOLDOFF_RESET = HOLDOFF_BITS'(60000);
  localparam logic [TRIGGER_BITS-1:0] TRIGGER_RESET = TRIGGER_BITS'(11);

  // Largest distance that fits the output field
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLDOFF = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TRIGGER = 1'b1;

endpackage

`default_nettype wire

FILE: src/ultrasonic_echo_ranger.sv
// Echo pulse-width ranger top level: trigger timing, echo timing, distance.
// Depends on uer_pkg.
`default_nettype none
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------------
//  in       | input     | in_valid / in_stall | in_echo_level, in_measure_request
//  out      | output    | out_valid/out_stall | out_trigger_level, out_distance_cm,
//           |           |                     | out_distance_new, out_request_taken
//  cfg      | input     | cfg_write_en        | cfg_index, cfg_data
//
// One item per cycle while in_stall is low; each item taken yields one registered result.
// The divide by 59 is tracked as a running quotient and remainder beside the
// echo counter, so the distance is ready on the falling edge with no divider.
// While out_stall holds a result, the next item is still taken and its result
// moves into a skid register; in_stall rises only when both output registers are full.
// Reset (rst_n low, synchronous) clears the counters and valid flags and restores register defaults.

module ultrasonic_echo_ranger
  import uer_pkg::*;
#(
  parameter int ECHO_COUNT_BITS = ECHO_COUNT_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // input items
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_echo_level,
  input  wire logic                      in_measure_request,
  // result items
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_trigger_level,
  output logic [DIST_BITS-1:0]           out_distance_cm,
  output logic                           out_distance_new,
  output logic                           out_request_taken,
  // configuration
  input  wire logic                      cfg_write_en,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // Quotient counter: 2^N / 59 < 2^(N-5)
  localparam int QUO_BITS = ECHO_COUNT_BITS - 5;
  localparam int CMP_BITS = (QUO_BITS > DIST_BITS) ? QUO_BITS : DIST_BITS;
  localparam logic [ECHO_COUNT_BITS-1:0] ECHO_MAX = {ECHO_COUNT_BITS{1'b1}};
  localparam logic [REM_BITS-1:0] REM_LAST = REM_BITS'(TICKS_PER_CM - 1);

  typedef struct packed {
    logic                 trigger_level;
    logic [DIST_BITS-1:0] distance_cm;
    logic                 distance_new;
    logic                 request_taken;
  } result_t;

  // Configuration registers
  logic [HOLDOFF_BITS-1:0] holdoff_ticks_r;
  logic [TRIGGER_BITS-1:0] trigger_ticks_r;

  // Tick state
  logic                       echo_before_r, echo_before_nxt;
  logic [ECHO_COUNT_BITS-1:0] echo_width_r, echo_width_nxt;
  logic [REM_BITS-1:0]        echo_rem_r, echo_rem_nxt;
  logic [QUO_BITS-1:0]        echo_quo_r, echo_quo_nxt;
  logic [HOLDOFF_BITS-1:0]    holdoff_left_r, holdoff_left_nxt;
  logic [TRIGGER_BITS-1:0]    trigger_left_r, trigger_left_nxt;
  logic [DIST_BITS-1:0]       distance_hold_r, distance_hold_nxt;

  // Output register and skid stage
  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r, result_nxt;

  logic accept;
  logic out_move;

  logic [HOLDOFF_BITS-1:0] holdoff_dec;
  logic [TRIGGER_BITS-1:0] trigger_cur;
  logic                    taken;
  logic                    fresh;
  logic [CMP_BITS-1:0]     quo_ext;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;
  assign out_move = !out_valid_r || !out_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holdoff_ticks_r <= HOLDOFF_RESET;
      trigger_ticks_r <= TRIGGER_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_HOLDOFF: holdoff_ticks_r <= cfg_data[HOLDOFF_BITS-1:0];
        CFG_TRIGGER: trigger_ticks_r <= cfg_data[TRIGGER_BITS-1:0];
        default:     ;
      endcase
    end
  end

  // Trigger and holdoff for this tick
  always_comb begin
    holdoff_dec      = (holdoff_left_r != '0) ? holdoff_left_r - 1'b1 : holdoff_left_r;
    taken            = in_measure_request && (holdoff_dec == '0);
    holdoff_left_nxt = taken ? holdoff_ticks_r : holdoff_dec;
    trigger_cur      = taken ? trigger_ticks_r : trigger_left_r;
    trigger_left_nxt = (trigger_cur != '0) ? trigger_cur - 1'b1 : trigger_cur;
  end

  // Echo timing with a running quotient and remainder of width / 59
  always_comb begin
    echo_width_nxt    = echo_width_r;
    echo_rem_nxt      = echo_rem_r;
    echo_quo_nxt      = echo_quo_r;
    distance_hold_nxt = distance_hold_r;
    fresh             = 1'b0;
    quo_ext           = CMP_BITS'(echo_quo_r);
    if (in_echo_level) begin
      if (!echo_before_r) begin
        echo_width_nxt = ECHO_COUNT_BITS'(1);
        echo_rem_nxt   = REM_BITS'(1);
        echo_quo_nxt   = '0;
      end else if (echo_width_r != ECHO_MAX) begin
        echo_width_nxt = echo_width_r + 1'b1;
        if (echo_rem_r == REM_LAST) begin
          echo_rem_nxt = '0;
          echo_quo_nxt = echo_quo_r + 1'b1;
        end else begin
          echo_rem_nxt = echo_rem_r + 1'b1;
        end
      end
    end else if (echo_before_r && (echo_width_r != '0)) begin
      fresh = 1'b1;
      // saturate quotients beyond the output field
      if (quo_ext > CMP_BITS'(DIST_MAX)) begin
        distance_hold_nxt = DIST_MAX;
      end else begin
        distance_hold_nxt = quo_ext[DIST_BITS-1:0];
      end
    end
    echo_before_nxt = in_echo_level;
  end

  always_comb begin
    result_nxt.trigger_level = (trigger_cur != '0);
    result_nxt.distance_cm   = distance_hold_nxt;
    result_nxt.distance_new  = fresh;
    result_nxt.request_taken = taken;
  end

  // State update on every accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_before_r   <= 1'b0;
      echo_width_r    <= '0;
      echo_rem_r      <= '0;
      echo_quo_r      <= '0;
      holdoff_left_r  <= '0;
      trigger_left_r  <= '0;
      distance_hold_r <= '0;
    end else if (accept) begin
      echo_before_r   <= echo_before_nxt;
      echo_width_r    <= echo_width_nxt;
      echo_rem_r      <= echo_rem_nxt;
      echo_quo_r      <= echo_quo_nxt;
      holdoff_left_r  <= holdoff_left_nxt;
      trigger_left_r  <= trigger_left_nxt;
      distance_hold_r <= distance_hold_nxt;
    end
  end

  // Output register with skid stage behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_move) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
        if (accept) begin
          out_r <= result_nxt;
        end
      end
    end else if (accept) begin
      skid_r       <= result_nxt;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_trigger_level = out_r.trigger_level;
  assign out_distance_cm   = out_r.distance_cm;
  assign out_distance_new  = out_r.distance_new;
  assign out_request_taken = out_r.request_taken;

endmodule

`default_nettype wire

FILE: src/uer_checker.sv
// Port-level checker for the echo pulse-width ranger, bound to the top level.
// Depends on uer_pkg.
`default_nettype none

module uer_checker
  import uer_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_stall,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic                      out_trigger_level,
  input wire logic [DIST_BITS-1:0]      out_distance_cm,
  input wire logic                      out_distance_new,
  input wire logic                      out_request_taken
);

  // A stalled result item stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_distance_cm)
      && $stable(out_trigger_level) && $stable(out_distance_new)
      && $stable(out_request_taken))
    else $error("stalled result item changed");

  // Input stalls only while a result is waiting at the output
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output");

  // Once the output drains, the skid stage empties and input resumes
  a_stall_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && !out_stall |=> !in_stall)
    else $error("input stall held after output drained");

  // Every item taken with a free path shows up as a result next cycle
  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (.*);

`default_nettype wire

FILE: tb/sv/uer_range_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the echo ranger: predicts one reading per accepted tick and
// compares it with the next accepted result. Depends on uer_pkg.

module uer_range_checker
  import uer_pkg::*;
#(
  parameter int ECHO_BITS = ECHO_COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      in_echo_level,
  input  logic                      in_measure_request,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      out_trigger_level,
  input  logic [DIST_BITS-1:0]      out_distance_cm,
  input  logic                      out_distance_new,
  input  logic                      out_request_taken,
  input  logic                      cfg_write_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output int                        fail_count,
  output int                        outstanding
);

  localparam logic [ECHO_BITS-1:0] ECHO_SAT = {ECHO_BITS{1'b1}};

  typedef struct packed {
    logic                 trigger;
    logic [DIST_BITS-1:0] distance;
    logic                 fresh;
    logic                 taken;
  } reading_t;

  // register copies
  logic [HOLDOFF_BITS-1:0] holdoff_cfg;
  logic [TRIGGER_BITS-1:0] pulse_cfg;
  // ranger state
  logic                    echo_prev;
  logic [ECHO_BITS-1:0]    echo_ticks;
  logic [HOLDOFF_BITS-1:0] holdoff_cnt;
  logic [TRIGGER_BITS-1:0] pulse_cnt;
  logic [DIST_BITS-1:0]    dist_latched;

  reading_t pending_readings[$];
  int       errs = 0;

  // One microsecond tick of the ranger
  function automatic reading_t range_tick(input logic echo, input logic req);
    reading_t    r;
    int unsigned quot;
    r = '0;
    if (holdoff_cnt != 0) holdoff_cnt--;
    if (req && holdoff_cnt == 0) begin
      r.taken     = 1'b1;
      holdoff_cnt = holdoff_cfg;
      pulse_cnt   = pulse_cfg;
    end
    r.trigger = (pulse_cnt != 0);
    if (pulse_cnt != 0) pulse_cnt--;
    // echo timing; the rising tick counts as one
    if (echo) begin
      if (!echo_prev) echo_ticks = ECHO_BITS'(1);
      else if (echo_ticks != ECHO_SAT) echo_ticks++;
    end else if (echo_prev && echo_ticks != 0) begin
      quot         = echo_ticks / TICKS_PER_CM;
      dist_latched = (quot > DIST_MAX) ? DIST_MAX : quot[DIST_BITS-1:0];
      r.fresh      = 1'b1;
    end
    echo_prev  = echo;
    r.distance = dist_latched;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errs++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      holdoff_cfg  = HOLDOFF_RESET;
      pulse_cfg    = TRIGGER_RESET;
      echo_prev    = 1'b0;
      echo_ticks   = '0;
      holdoff_cnt  = '0;
      pulse_cnt    = '0;
      dist_latched = '0;
      pending_readings.delete();
    end else begin
      if (in_valid && !in_stall)
        pending_readings.push_back(range_tick(in_echo_level, in_measure_request));
      // compare accepted result against the oldest prediction
      if (out_valid && !out_stall) begin
        if (pending_readings.size() == 0) begin
          errs++;
          $display("%0t: result with no tick pending: expected none, got distance %0d",
                   $time, out_distance_cm);
        end else begin
          want = pending_readings.pop_front();
          check_field("trigger_level", 16'(want.trigger), 16'(out_trigger_level));
          check_field("distance_cm", 16'(want.distance), 16'(out_distance_cm));
          check_field("distance_new", 16'(want.fresh), 16'(out_distance_new));
          check_field("request_taken", 16'(want.taken), 16'(out_request_taken));
        end
      end
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_HOLDOFF: holdoff_cfg = cfg_data[HOLDOFF_BITS-1:0];
          CFG_TRIGGER: pulse_cfg = cfg_data[TRIGGER_BITS-1:0];
          default: ;
        endcase
      end
    end
    fail_count  <= errs;
    outstanding <= pending_readings.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the echo ranger testbench: clock, reset, tick stimulus, register
// settings and verdict. Depends on uer_pkg, ultrasonic_echo_ranger, uer_range_checker.

module tb_top;
  import uer_pkg::*;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_echo_level = 1'b0;
  logic                      in_measure_request = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_trigger_level;
  logic [DIST_BITS-1:0]      out_distance_cm;
  logic                      out_distance_new;
  logic                      out_request_taken;
  logic                      cfg_write_en = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_HOLDOFF;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  int fail_count;
  int outstanding;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int ticks_sent = 0;
  int settings_used = 1;

  ultrasonic_echo_ranger #(
    .ECHO_COUNT_BITS(ECHO_COUNT_BITS_DEF)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_echo_level(in_echo_level),
    .in_measure_request(in_measure_request),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_trigger_level(out_trigger_level),
    .out_distance_cm(out_distance_cm),
    .out_distance_new(out_distance_new),
    .out_request_taken(out_request_taken),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  uer_range_checker #(
    .ECHO_BITS(ECHO_COUNT_BITS_DEF)
  ) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_echo_level(in_echo_level),
    .in_measure_request(in_measure_request),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_trigger_level(out_trigger_level),
    .out_distance_cm(out_distance_cm),
    .out_distance_new(out_distance_new),
    .out_request_taken(out_request_taken),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count),
    .outstanding(outstanding)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // run limit
  initial begin
    #30_000_000;
    $display("timeout: ranger stopped making progress");
    $display("end of test: mismatches");
    $finish;
  end

  // Present one tick, with an optional random gap first; returns at acceptance
  task automatic send_tick(input logic echo, input logic req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_echo_level      <= echo;
    in_measure_request <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
  endtask

  // Write both registers once every pending reading has come back
  task automatic apply_setting(input logic [CFG_DATA_BITS-1:0] holdoff,
                               input logic [CFG_DATA_BITS-1:0] trigger);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_HOLDOFF;
    cfg_data     <= holdoff;
    @(posedge clk);
    cfg_index    <= CFG_TRIGGER;
    cfg_data     <= trigger;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    settings_used++;
  endtask

  // Mostly measurement cycles (request, quiet gap, echo pulse), some noise
  task automatic run_ranging(input int n_ticks);
    int done_ticks;
    int gap;
    int width;
    int k;
    done_ticks = 0;
    while (done_ticks < n_ticks) begin
      if ($urandom_range(9) < 7) begin
        gap = $urandom_range(0, 12);
        send_tick(1'b0, 1'b1);
        for (k = 0; k < gap; k++) send_tick(1'b0, $urandom_range(9) == 0);
        // pulse widths cluster around the 59 and 118 tick boundaries
        case ($urandom_range(3))
          0: width = $urandom_range(1, 5);
          1: width = $urandom_range(55, 64);
          2: width = $urandom_range(1, 120);
          default: width = $urandom_range(114, 124);
        endcase
        for (k = 0; k < width; k++) send_tick(1'b1, $urandom_range(19) == 0);
        done_ticks += 1 + gap + width;
      end else begin
        width = $urandom_range(1, 16);
        for (k = 0; k < width; k++)
          send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        done_ticks += width;
      end
    end
  endtask

  initial begin
    logic [CFG_DATA_BITS-1:0] trig_word;
    int k;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: first request taken, second blocked by holdoff,
    // short echo pulses while the trigger is high
    send_idle_pct = 20;
    recv_idle_pct = 79;
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    for (k = 0; k < 8; k++) send_tick(1'b0, 1'b0);

    // zero holdoff and zero trigger width: every request taken, trigger low
    apply_setting('0, '0);
    for (k = 0; k < 4; k++) send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    run_ranging(150);

    // holdoff shorter than the widest pulse: pulse restarts
    apply_setting(CFG_DATA_BITS'(3), CFG_DATA_BITS'(1023));
    run_ranging(150);

    send_idle_pct = 79;
    recv_idle_pct = 20;
    apply_setting(CFG_DATA_BITS'(1), CFG_DATA_BITS'(1));
    run_ranging(150);

    apply_setting(CFG_DATA_BITS'(25), CFG_DATA_BITS'(7));
    run_ranging(150);

    // random setting, trigger word with junk above the register width
    send_idle_pct = 0;
    recv_idle_pct = 0;
    trig_word = CFG_DATA_BITS'($urandom);
    trig_word[TRIGGER_BITS-1:0] = TRIGGER_BITS'($urandom_range(1, 40));
    apply_setting(CFG_DATA_BITS'($urandom_range(0, 60)), trig_word);
    run_ranging(150);

    // largest holdoff: one request taken, the rest held off
    apply_setting({CFG_DATA_BITS{1'b1}}, CFG_DATA_BITS'(1023));
    run_ranging(130);

    // drain
    in_valid <= 1'b0;
    @(posedge clk);
    for (k = 0; k < 2000 && outstanding != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (outstanding != 0) $display("%0d readings never arrived", outstanding);

    $display("ran %0d ticks under %0d register settings: defaults, holdoff 0 to max,",
             ticks_sent, settings_used);
    $display("trigger width 0 to 1023, echo pulses from one tick to about 124 ticks");
    if (fail_count == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
